// ----- rtl/pdq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package pdq_pkg;
    localparam int QUEUE_CAPACITY = 64;
    localparam int IDX_W = (QUEUE_CAPACITY > 1) ? $clog2(QUEUE_CAPACITY) : 1;
    localparam int CNT_W = $clog2(QUEUE_CAPACITY + 1);

    localparam logic [1:0] ACT_ENQUEUE = 2'd0;
    localparam logic [1:0] ACT_FLUSH   = 2'd1;
    localparam logic [1:0] ACT_DISCARD = 2'd2;
    localparam logic [1:0] ACT_PURGE   = 2'd3;

    localparam logic [1:0] DISP_FLUSHED  = 2'd0;
    localparam logic [1:0] DISP_FULL     = 2'd1;
    localparam logic [1:0] DISP_NO_ROUTE = 2'd2;
    localparam logic [1:0] DISP_TIMEOUT  = 2'd3;

    typedef struct packed {
        logic [15:0] dest;
        logic [15:0] handle;
        logic [31:0] stamp;
        logic [31:0] order;
    } t_entry;

    typedef struct packed {
        logic        vld;
        logic [15:0] handle;
        logic [15:0] dest;
        logic [1:0]  disp;
        logic        last;
    } t_result;
endpackage
`default_nettype wire

// ----- rtl/pdq_mem.sv -----
`timescale 1ns / 1ps
`default_nettype none
module pdq_mem import pdq_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [IDX_W-1:0] i_waddr,
    input  wire t_entry           i_wdata,
    input  wire logic             i_re,
    input  wire logic [IDX_W-1:0] i_raddr,
    output t_entry                o_rdata
);
    t_entry r_mem [QUEUE_CAPACITY];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

// ----- rtl/pdq_out.sv -----
`timescale 1ns / 1ps
`default_nettype none
module pdq_out import pdq_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_result i_push,
    output logic        o_ready,
    input  wire logic   i_out_stall,
    output logic        o_out_valid,
    output logic [15:0] o_out_handle,
    output logic [15:0] o_out_dest,
    output logic [1:0]  o_disposition,
    output logic        o_last
);
    logic        r_vld;
    logic [15:0] r_handle;
    logic [15:0] r_dest;
    logic [1:0]  r_disp;
    logic        r_last;

    assign o_ready = !r_vld || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_push.vld) begin
            r_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.vld) begin
            r_handle <= i_push.handle;
            r_dest   <= i_push.dest;
            r_disp   <= i_push.disp;
            r_last   <= i_push.last;
        end
    end

    assign o_out_valid   = r_vld;
    assign o_out_handle  = r_handle;
    assign o_out_dest    = r_dest;
    assign o_disposition = r_disp;
    assign o_last        = r_last;
endmodule
`default_nettype wire

// ----- rtl/pdq_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module pdq_ctrl import pdq_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_action,
    input  wire logic [15:0] i_dest,
    input  wire logic [15:0] i_packet_handle,
    input  wire logic [31:0] i_now_time,
    input  wire logic [31:0] i_timeout,
    output t_result          o_push,
    input  wire logic        i_out_ready
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_VSEL  = 3'd2;
    localparam logic [2:0] S_VCAP  = 3'd3;
    localparam logic [2:0] S_VSCAN = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;
    localparam logic [2:0] S_WRITE = 3'd6;

    localparam logic [CNT_W-1:0] CAP  = CNT_W'(QUEUE_CAPACITY);
    localparam logic [IDX_W-1:0] LAST = IDX_W'(QUEUE_CAPACITY - 1);

    logic [2:0]          r_state;
    logic [QUEUE_CAPACITY-1:0] r_valid;
    logic [CNT_W-1:0]    r_occ;
    logic [31:0]         r_ic;
    logic [1:0]          r_act;
    logic [15:0]         r_dest;
    logic [15:0]         r_handle;
    logic [31:0]         r_now;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_pvld;
    logic [IDX_W-1:0]    r_pidx;
    logic                r_found;
    logic                r_two;
    logic [IDX_W-1:0]    r_b_idx;
    logic [15:0]         r_b_dest;
    logic [15:0]         r_b_handle;
    logic [31:0]         r_b_order;
    logic [31:0]         r_b_age;
    logic [IDX_W-1:0]    r_i;
    logic [15:0]         r_c_dest;
    logic [15:0]         r_c_handle;
    logic [31:0]         r_c_stamp;
    logic [31:0]         r_c_order;
    logic                r_front;
    logic [1:0]          r_disp;
    logic                r_last;

    t_entry              rd_data;
    t_entry              wr_data;
    logic                rd_en;
    logic [IDX_W-1:0]    rd_addr;
    logic [IDX_W-1:0]    free_idx;
    logic                vj;
    logic                elig;
    logic                older;
    logic                better;
    logic                kill;
    logic                front_n;
    logic [31:0]         age_j;
    logic [31:0]         age_c;
    logic                take_c;
    logic                scan_end;
    logic                push;

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_cnt[IDX_W-1:0];
        if ((r_state == S_SCAN || r_state == S_VSCAN) && r_cnt < CAP) begin
            rd_en = 1'b1;
        end else if (r_state == S_VSEL && r_valid[r_i]) begin
            rd_en   = 1'b1;
            rd_addr = r_i;
        end
    end

    always_comb begin
        free_idx = '0;
        for (int k = QUEUE_CAPACITY - 1; k >= 0; k--) begin
            if (!r_valid[k]) begin
                free_idx = IDX_W'(k);
            end
        end
    end

    assign wr_data = '{dest: r_dest, handle: r_handle, stamp: r_now, order: r_ic};

    pdq_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (r_state == S_WRITE),
        .i_waddr (free_idx),
        .i_wdata (wr_data),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    always_comb begin
        vj       = r_pvld && r_valid[r_pidx];
        age_j    = r_now - rd_data.stamp;
        older    = (r_ic - rd_data.order) > (r_ic - r_b_order);
        elig     = vj && ((r_act == ACT_PURGE) ? (age_j >= i_timeout)
                                               : (rd_data.dest == r_dest));
        better   = !r_found || ((r_act == ACT_PURGE)
                   ? (rd_data.dest < r_b_dest || (rd_data.dest == r_b_dest && older))
                   : older);
        kill     = vj && (r_pidx != r_i) && (rd_data.dest == r_c_dest) &&
                   ((r_ic - rd_data.order) > (r_ic - r_c_order));
        front_n  = r_front && !kill;
        age_c    = r_now - r_c_stamp;
        take_c   = !r_found || age_c > r_b_age || (age_c == r_b_age && r_c_dest < r_b_dest);
        scan_end = r_pvld && (r_pidx == LAST);
        push     = (r_state == S_EMIT) && i_out_ready;
    end

    assign o_push = '{vld: push, handle: r_b_handle, dest: r_b_dest,
                      disp: r_disp, last: r_last};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
            r_occ   <= '0;
            r_ic    <= '0;
            r_pvld  <= 1'b0;
            r_found <= 1'b0;
        end else begin
            r_pvld <= rd_en && (r_state != S_VSEL);
            if (rd_en && r_state != S_VSEL) begin
                r_cnt  <= r_cnt + CNT_W'(1);
                r_pidx <= r_cnt[IDX_W-1:0];
            end
            unique case (r_state)
                S_IDLE: begin
                    r_cnt   <= '0;
                    r_found <= 1'b0;
                    r_two   <= 1'b0;
                    r_i     <= '0;
                    if (i_in_valid) begin
                        r_act    <= i_action;
                        r_dest   <= i_dest;
                        r_handle <= i_packet_handle;
                        r_now    <= i_now_time;
                        unique case (i_action)
                            ACT_ENQUEUE: r_state <= (r_occ >= CAP) ? S_VSEL : S_WRITE;
                            ACT_FLUSH:   begin r_state <= S_SCAN; r_disp <= DISP_FLUSHED; end
                            ACT_DISCARD: begin r_state <= S_SCAN; r_disp <= DISP_NO_ROUTE; end
                            ACT_PURGE:   begin r_state <= S_SCAN; r_disp <= DISP_TIMEOUT; end
                            default:     r_state <= S_IDLE;
                        endcase
                    end
                end
                S_SCAN: begin
                    if (elig) begin
                        if (r_found) begin
                            r_two <= 1'b1;
                        end
                        if (better) begin
                            r_found    <= 1'b1;
                            r_b_idx    <= r_pidx;
                            r_b_dest   <= rd_data.dest;
                            r_b_handle <= rd_data.handle;
                            r_b_order  <= rd_data.order;
                        end
                    end
                    if (scan_end) begin
                        r_last  <= !(r_two || (r_found && elig));
                        r_state <= (r_found || elig) ? S_EMIT : S_IDLE;
                    end
                end
                S_VSEL: begin
                    if (r_valid[r_i]) begin
                        r_state <= S_VCAP;
                    end else if (r_i == LAST) begin
                        r_disp  <= DISP_FULL;
                        r_last  <= 1'b1;
                        r_state <= S_EMIT;
                    end else begin
                        r_i <= r_i + IDX_W'(1);
                    end
                end
                S_VCAP: begin
                    r_c_dest   <= rd_data.dest;
                    r_c_handle <= rd_data.handle;
                    r_c_stamp  <= rd_data.stamp;
                    r_c_order  <= rd_data.order;
                    r_front    <= 1'b1;
                    r_cnt      <= '0;
                    r_state    <= S_VSCAN;
                end
                S_VSCAN: begin
                    r_front <= front_n;
                    if (scan_end) begin
                        if (front_n && take_c) begin
                            r_found    <= 1'b1;
                            r_b_idx    <= r_i;
                            r_b_dest   <= r_c_dest;
                            r_b_handle <= r_c_handle;
                            r_b_age    <= age_c;
                        end
                        if (r_i == LAST) begin
                            r_disp  <= DISP_FULL;
                            r_last  <= 1'b1;
                            r_state <= S_EMIT;
                        end else begin
                            r_i     <= r_i + IDX_W'(1);
                            r_state <= S_VSEL;
                        end
                    end
                end
                S_EMIT: begin
                    if (push) begin
                        r_valid[r_b_idx] <= 1'b0;
                        r_occ   <= r_occ - CNT_W'(1);
                        r_cnt   <= '0;
                        r_found <= 1'b0;
                        r_two   <= 1'b0;
                        if (r_act == ACT_ENQUEUE) begin
                            r_state <= S_WRITE;
                        end else if (r_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_WRITE: begin
                    r_valid[free_idx] <= 1'b1;
                    r_occ   <= r_occ + CNT_W'(1);
                    r_ic    <= r_ic + 32'd1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_occ_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ == CNT_W'($countones(r_valid)))
        else $error("occupancy out of step with valid bits");
    a_emit_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> r_found)
        else $error("result issued with no entry selected");
    a_write_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE) |-> (r_occ < CAP))
        else $error("insert into full queue");
    a_push_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |=> !r_valid[$past(r_b_idx)])
        else $error("reported entry still valid");
endmodule
`default_nettype wire

// ----- rtl/per_destination_pending_queue.sv -----
// Enqueue with room goes straight to the write; enqueue into a full queue runs
//   an oldest-front search over the slot RAM for 64 candidates, then emits and writes.
// Flush, discard and purge: each result takes a scan of the slot RAM plus hand-off;
//   a request that matches nothing takes one scan.
// One request at a time; a finished result waits in the output register.
// Reset (synchronous, active low) empties the queue and sets timeout to 10000.
`timescale 1ns / 1ps
`default_nettype none
module per_destination_pending_queue import pdq_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_action,
    input  wire logic [15:0] i_dest,
    input  wire logic [15:0] i_packet_handle,
    input  wire logic [31:0] i_now_time,
    input  wire logic        i_cfg_we,
    input  wire logic [31:0] i_cfg_wdata,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [15:0]      o_out_handle,
    output logic [15:0]      o_out_dest,
    output logic [1:0]       o_disposition,
    output logic             o_last
);
    logic [31:0] r_queue_timeout;
    t_result     push;
    logic        out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_queue_timeout <= 32'd10000;
        end else if (i_cfg_we) begin
            r_queue_timeout <= i_cfg_wdata;
        end
    end

    pdq_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_action        (i_action),
        .i_dest          (i_dest),
        .i_packet_handle (i_packet_handle),
        .i_now_time      (i_now_time),
        .i_timeout       (r_queue_timeout),
        .o_push          (push),
        .i_out_ready     (out_ready)
    );

    pdq_out u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_ready       (out_ready),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_out_handle  (o_out_handle),
        .o_out_dest    (o_out_dest),
        .o_disposition (o_disposition),
        .o_last        (o_last)
    );
endmodule
`default_nettype wire
